[rtl/assert_macros.svh]
// Assertion helpers used by the decompressor unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CHK_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/lzss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lzss_pkg;

	// History window
	localparam int HIST_DEPTH = 4096;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);

	// Running length counter width (matches total_length)
	localparam int LEN_W = 24;

	// Copy length is the count low nibble plus this bias
	localparam int COPY_BIAS = 2;
	localparam int REM_W     = 5;

	// Number of flags supplied by one tag byte
	localparam int FLAG_N = 8;
	localparam int LEFT_W = 4;

	// Parser position in the compressed stream
	typedef enum logic [1:0] {
		PH_TAG,
		PH_ITEM,
		PH_OFFSET
	} phase_t;

	// Sequencer state
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

[rtl/lzss_stream_decompressor_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// src       in         src_valid/src_stall   in_byte
// dst       out        dst_valid/dst_stall   out_byte, last_of_run, end_of_stream, total_length
//
// Tag, count and literal bytes and the end marker are each consumed on acceptance. An offset
// byte is accepted in ST_IDLE, then each copied byte (2 to 17 per copy) goes through ST_READ
// (history read) and ST_EMIT (write and output), as the history's read-after-write requires.
// History is not swept after reset or end of stream: entries at or past the stream's
// fill count read as zero, so a new stream starts at once.
// A stalled output holds the sequencer; src is taken only while idle with output room.

module lzss_stream_decompressor_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [7:0]                 in_byte,
	input  wire logic                       src_valid,
	output logic                            src_stall,
	output logic [7:0]                      out_byte,
	output logic                            last_of_run,
	output logic                            end_of_stream,
	output logic [lzss_pkg::LEN_W-1:0]      total_length,
	output logic                            dst_valid,
	input  wire logic                       dst_stall
);
	import lzss_pkg::*;

	`include "assert_macros.svh"

	state_t               state_q, state_d;
	phase_t               phase_q, phase_d;
	logic [FLAG_N-1:0]    flags_q, flags_d;
	logic [LEFT_W-1:0]    left_q, left_d;
	logic [7:0]           cnt_q, cnt_d;
	logic [HIST_AW-1:0]   dist_q, dist_d;
	logic [REM_W-1:0]     rem_q, rem_d;
	logic [HIST_AW-1:0]   wp_q, wp_d;
	logic [LEN_W-1:0]     len_q, len_d;
	logic                 out_valid_q, out_valid_d;

	logic [7:0]           out_byte_q, ob_d;
	logic                 last_q, last_d;
	logic                 eos_q, eos_d;
	logic [LEN_W-1:0]     tlen_q, tlen_d;
	logic                 out_load;

	logic [7:0]           hist_mem [HIST_DEPTH];
	logic [7:0]           hist_rd_q;
	logic                 hist_we;
	logic [7:0]           hist_wdata;
	logic [HIST_AW-1:0]   rd_addr;
	logic                 src_ok;

	logic                 out_free;
	logic                 accept;
	logic [LEN_W-1:0]     len_inc;
	logic [LEFT_W-1:0]    left_dec;
	logic [7:0]           copy_byte;

	// Handshake
	assign out_free  = !out_valid_q || !dst_stall;
	assign src_stall = !((state_q == ST_IDLE) && out_free);
	assign accept    = src_valid && !src_stall;

	// Copy source and fill check: only the first len_q entries exist in this stream
	assign rd_addr   = wp_q - dist_q;
	assign src_ok    = (len_q[LEN_W-1:HIST_AW] != '0) || (rd_addr < len_q[HIST_AW-1:0]);
	assign copy_byte = src_ok ? hist_rd_q : 8'd0;

	// Saturating length and flag bookkeeping
	assign len_inc  = (len_q == '1) ? len_q : len_q + 1'b1;
	assign left_dec = (left_q != '0) ? left_q - 1'b1 : '0;

	// Next state and outputs
	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		flags_d     = flags_q;
		left_d      = left_q;
		cnt_d       = cnt_q;
		dist_d      = dist_q;
		rem_d       = rem_q;
		wp_d        = wp_q;
		len_d       = len_q;
		out_valid_d = out_valid_q && dst_stall;
		out_load    = 1'b0;
		ob_d        = in_byte;
		last_d      = 1'b1;
		eos_d       = 1'b0;
		tlen_d      = len_inc;
		hist_we     = 1'b0;
		hist_wdata  = in_byte;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (phase_q)
						PH_TAG: begin
							flags_d = in_byte;
							left_d  = LEFT_W'(FLAG_N);
							phase_d = PH_ITEM;
						end
						PH_ITEM: begin
							priority if (!flags_q[FLAG_N-1]) begin
								// literal
								hist_we  = 1'b1;
								wp_d     = wp_q + 1'b1;
								len_d    = len_inc;
								out_load = 1'b1;
								flags_d  = flags_q << 1;
								left_d   = left_dec;
								phase_d  = (left_dec == '0) ? PH_TAG : PH_ITEM;
							end else if (in_byte == 8'd0) begin
								// end marker: report length, start a new stream
								out_load = 1'b1;
								ob_d     = 8'd0;
								eos_d    = 1'b1;
								tlen_d   = len_q;
								wp_d     = '0;
								len_d    = '0;
								flags_d  = '0;
								left_d   = '0;
								cnt_d    = '0;
								phase_d  = PH_TAG;
							end else begin
								cnt_d   = in_byte;
								phase_d = PH_OFFSET;
							end
						end
						PH_OFFSET: begin
							dist_d  = {cnt_q[7:4], in_byte};
							rem_d   = REM_W'(cnt_q[3:0]) + REM_W'(COPY_BIAS);
							state_d = ST_READ;
						end
						default: begin
							phase_d = PH_TAG;
						end
					endcase
				end
			end
			ST_READ: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					hist_we    = 1'b1;
					hist_wdata = copy_byte;
					wp_d       = wp_q + 1'b1;
					len_d      = len_inc;
					out_load   = 1'b1;
					ob_d       = copy_byte;
					last_d     = (rem_q == REM_W'(1));
					rem_d      = rem_q - 1'b1;
					if (rem_q == REM_W'(1)) begin
						cnt_d   = '0;
						flags_d = flags_q << 1;
						left_d  = left_dec;
						phase_d = (left_dec == '0) ? PH_TAG : PH_ITEM;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (out_load) begin
			out_valid_d = 1'b1;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_TAG;
			flags_q     <= '0;
			left_q      <= '0;
			cnt_q       <= '0;
			dist_q      <= '0;
			rem_q       <= '0;
			wp_q        <= '0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			phase_q     <= phase_d;
			flags_q     <= flags_d;
			left_q      <= left_d;
			cnt_q       <= cnt_d;
			dist_q      <= dist_d;
			rem_q       <= rem_d;
			wp_q        <= wp_d;
			len_q       <= len_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= ob_d;
			last_q     <= last_d;
			eos_q      <= eos_d;
			tlen_q     <= tlen_d;
		end
	end

	// History memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[wp_q] <= hist_wdata;
		end
		hist_rd_q <= hist_mem[rd_addr];
	end

	assign out_byte      = out_byte_q;
	assign last_of_run   = last_q;
	assign end_of_stream = eos_q;
	assign total_length  = tlen_q;
	assign dst_valid     = out_valid_q;

	// Checks
	`CHK_IMPLY(a_copy_nonempty, (state_q != ST_IDLE), (rem_q != '0),
		"copy in progress with no bytes left")
	`CHK_IMPLY(a_offset_count, (phase_q == PH_OFFSET), (cnt_q != 8'd0),
		"offset phase without a nonzero count")
	`CHK_IMPLY(a_end_result, (out_valid_q && eos_q), (out_byte_q == 8'd0 && last_q),
		"end result must carry a zero byte and close the run")
	`CHK_NEXT(a_new_stream, (out_load && eos_d), (wp_q == '0 && len_q == '0),
		"stream state not restarted after end marker")

endmodule

`default_nettype wire
